FILE: rtl/ppu_pkg.sv
`default_nettype none

package ppu_pkg;

    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int COLOR_W = 6;
    localparam int INDEX_W = 4;
    localparam int LEVEL_W = 8;

    localparam logic FUNC_PALETTE = 1'b0;
    localparam logic FUNC_VIDEO   = 1'b1;

    localparam logic [1:0] RES_TWO  = 2'd0;
    localparam logic [1:0] RES_FOUR = 2'd1;

    typedef enum logic [1:0] {
        CFG_MONITOR_IS_RGB   = 2'd0,
        CFG_COLOR_RESOLUTION = 2'd1,
        CFG_ROW_WIDTH_CODE   = 2'd2
    } t_cfg_index;

    localparam logic [COLOR_W-1:0] COMPOSITE_MAP [64] = '{
        6'd0,  6'd21, 6'd2,  6'd20, 6'd49, 6'd6,  6'd35, 6'd36,
        6'd33, 6'd27, 6'd14, 6'd9,  6'd1,  6'd10, 6'd3,  6'd28,
        6'd7,  6'd17, 6'd18, 6'd22, 6'd48, 6'd34, 6'd34, 6'd32,
        6'd37, 6'd40, 6'd42, 6'd13, 6'd8,  6'd11, 6'd24, 6'd45,
        6'd56, 6'd19, 6'd16, 6'd50, 6'd54, 6'd52, 6'd38, 6'd36,
        6'd46, 6'd45, 6'd41, 6'd15, 6'd9,  6'd25, 6'd27, 6'd30,
        6'd63, 6'd58, 6'd58, 6'd51, 6'd55, 6'd53, 6'd39, 6'd60,
        6'd47, 6'd61, 6'd43, 6'd57, 6'd29, 6'd31, 6'd59, 6'd63
    };

    // two-bit level times 0x55 is the pair repeated four times
    function automatic logic [LEVEL_W-1:0] level(input logic hi, input logic lo);
        level = {4{hi, lo}};
    endfunction

    typedef struct packed {
        logic                valid;
        logic [INDEX_W-1:0]  idx;
        logic                hit;
        logic                last;
    } t_pix_req;

endpackage

`default_nettype wire

FILE: rtl/ppu_ram.sv
`default_nettype none

module ppu_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read and a write in the same cycle see the old entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/palette_pixel_unpacker_core.sv
`default_nettype none

// Graphics pixel unpacker with a palette.
// Input stream (s_axis): tuser selects a palette write or a video byte. A palette
// write stores tdata[9:4] in slot tdata[3:0] and gives no output. A video byte
// (tdata[11:4]) is split MSB first into 8, 4 or 2 palette indices and each index
// is repeated over the row's screen pixels; one output transfer per pixel.
// Output stream (m_axis): red, green, blue and the palette index, tlast on the
// final pixel of a byte.
// Config channel: index 0 monitor_is_rgb, 1 color_resolution, 2 row_width_code;
// always ready; the user must write it only while the block is idle (unchecked).
// Pixels of a byte pass the sequencer, the read stage and the output register.
// Throughput: one pixel per cycle while m_axis does not stall, from a sequencer
// that reads the palette RAM once per pixel; a byte gives 4 to 32 pixels. The
// next item is taken in the cycle the last pixel read of the current byte issues.
// Reset clears config, busy, stage and palette valid bits (entries read as zero).
// A stalled m_axis holds the output register and then the read stage and the
// sequencer; s_axis_tready drops until the sequencer frees up.

module palette_pixel_unpacker_core
    import ppu_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // palette_slot[3:0], data[11:4], zero
    input  wire logic        s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16],
                                            // pixel_index[27:24], zero
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [1:0]  i_cfg_data
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic       r_rgb;
    logic [1:0] r_res;
    logic [1:0] r_rwc;

    logic [INDEX_W-1:0] in_slot;
    logic [7:0]         in_data;
    logic               in_acc;
    logic               wr_acc;
    logic               byte_acc;
    logic               wr_in_range;

    logic               r_busy;
    logic [1:0]         r_mode;
    logic [7:0]         r_sh;
    logic [2:0]         r_k;
    logic [2:0]         r_k_last;
    logic [3:0]         r_r;
    logic [3:0]         r_rep_last;
    logic               n_busy;
    logic [1:0]         n_mode;
    logic [7:0]         n_sh;
    logic [2:0]         n_k;
    logic [2:0]         n_k_last;
    logic [3:0]         n_r;
    logic [3:0]         n_rep_last;

    logic [2:0]         plog;
    logic [2:0]         rep_sum;
    logic [2:0]         rep_log;

    logic [INDEX_W-1:0] seq_idx;
    logic               seq_issue;
    logic               seq_last;
    logic               seq_in_range;

    logic [PALETTE_ENTRIES-1:0] r_valid;
    logic [COLOR_W-1:0]         ram_rdata;

    t_pix_req r_b;
    logic     b_ready;
    logic     c_ready;

    logic [COLOR_W-1:0] stored;
    logic [COLOR_W-1:0] shown;
    logic               r_c_valid;
    logic [31:0]        r_c_data;
    logic               r_c_last;

    assign in_slot  = s_axis_tdata[3:0];
    assign in_data  = s_axis_tdata[11:4];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign wr_acc   = in_acc && (s_axis_tuser == FUNC_PALETTE);
    assign byte_acc = in_acc && (s_axis_tuser == FUNC_VIDEO);
    assign wr_in_range = {1'b0, in_slot} < (INDEX_W + 1)'(PALETTE_ENTRIES);

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgb <= 1'b0;
            r_res <= 2'd0;
            r_rwc <= 2'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MONITOR_IS_RGB:   r_rgb <= i_cfg_data[0];
                CFG_COLOR_RESOLUTION: r_res <= i_cfg_data;
                CFG_ROW_WIDTH_CODE:   r_rwc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pixel sequencer
    always_comb begin
        case (r_mode)
            RES_TWO:  seq_idx = {3'd0, r_sh[7]};
            RES_FOUR: seq_idx = {2'd0, r_sh[7:6]};
            default:  seq_idx = r_sh[7:4];
        endcase
    end

    assign b_ready   = !r_b.valid || c_ready;
    assign seq_issue = r_busy && b_ready;
    assign seq_last  = (r_k == r_k_last) && (r_r == r_rep_last);
    assign seq_in_range = {1'b0, seq_idx} < (INDEX_W + 1)'(PALETTE_ENTRIES);

    assign s_axis_tready = !r_busy || (seq_issue && seq_last);

    always_comb begin
        case (r_res)
            RES_TWO:  plog = 3'd3;
            RES_FOUR: plog = 3'd2;
            default:  plog = 3'd1;
        endcase
        rep_sum = plog + {1'b0, r_rwc};
        rep_log = (rep_sum >= 3'd5) ? 3'd0 : 3'd5 - rep_sum;
    end

    always_comb begin
        n_busy     = r_busy;
        n_mode     = r_mode;
        n_sh       = r_sh;
        n_k        = r_k;
        n_k_last   = r_k_last;
        n_r        = r_r;
        n_rep_last = r_rep_last;
        if (seq_issue) begin
            if (seq_last) begin
                n_busy = 1'b0;
            end else if (r_r == r_rep_last) begin
                n_r = 4'd0;
                n_k = r_k + 3'd1;
                case (r_mode)
                    RES_TWO:  n_sh = {r_sh[6:0], 1'b0};
                    RES_FOUR: n_sh = {r_sh[5:0], 2'b0};
                    default:  n_sh = {r_sh[3:0], 4'b0};
                endcase
            end else begin
                n_r = r_r + 4'd1;
            end
        end
        if (byte_acc) begin
            n_busy     = 1'b1;
            n_mode     = r_res;
            n_sh       = in_data;
            n_k        = 3'd0;
            n_r        = 4'd0;
            n_k_last   = 3'((4'd1 << plog) - 4'd1);
            n_rep_last = 4'((5'd1 << rep_log) - 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_mode     <= n_mode;
        r_sh       <= n_sh;
        r_k        <= n_k;
        r_k_last   <= n_k_last;
        r_r        <= n_r;
        r_rep_last <= n_rep_last;
    end

    // palette store: a write and a read of the same cycle return the old color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_acc && wr_in_range) begin
            r_valid[in_slot[AW-1:0]] <= 1'b1;
        end
    end

    ppu_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (wr_acc && wr_in_range),
        .i_waddr (in_slot[AW-1:0]),
        .i_wdata (in_data[COLOR_W-1:0]),
        .i_re    (seq_issue),
        .i_raddr (seq_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (b_ready) begin
            r_b.valid <= seq_issue;
        end
        if (seq_issue) begin
            r_b.idx  <= seq_idx;
            r_b.hit  <= seq_in_range && r_valid[seq_idx[AW-1:0]];
            r_b.last <= seq_last;
        end
    end

    // output register
    assign c_ready = !r_c_valid || m_axis_tready;
    assign stored  = r_b.hit ? ram_rdata : '0;
    assign shown   = r_rgb ? stored : COMPOSITE_MAP[stored];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b.valid;
        end
        if (c_ready && r_b.valid) begin
            r_c_data <= {4'd0, r_b.idx, level(shown[3], shown[0]),
                         level(shown[4], shown[1]), level(shown[5], shown[2])};
            r_c_last <= r_b.last;
        end
    end

    assign m_axis_tvalid = r_c_valid;
    assign m_axis_tdata  = r_c_data;
    assign m_axis_tlast  = r_c_last;

    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b.valid && !b_ready |=> r_b.valid && $stable(r_b.idx) && $stable(r_b.last))
        else $error("read stage lost a pixel under stall");

    a_seq_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k <= r_k_last) && (r_r <= r_rep_last))
        else $error("sequencer counter out of range");

    a_seq_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_issue && seq_last && !byte_acc |=> !r_busy)
        else $error("sequencer stayed busy after the last pixel");

    a_byte_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        byte_acc |=> r_busy && (r_k == 3'd0) && (r_r == 4'd0))
        else $error("video byte not loaded into the sequencer");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_acc |-> !r_busy || seq_last)
        else $error("palette write taken while earlier reads remain");

endmodule

`default_nettype wire
